/* src/aht_pkg.sv */
// package for the abbreviation hash table: word types, commands, status codes
// no dependencies
package aht_pkg;

	localparam int SLOTS_DEF = 128;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO_CODE = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] unit_offset;
		logic [31:0] abbrev_code;
		logic [15:0] tag_in;
		logic        children_in;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [6:0]  slot;
		logic [15:0] tag_out;
		logic        children_out;
		logic [6:0]  entry_count;
	} out_word_t;

	// classified job handed from front to back
	typedef enum logic [1:0] {
		JOB_PROBE = 2'd0,
		JOB_CLEAR = 2'd1,
		JOB_FIXED = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        is_insert;
		logic [2:0]  fixed_status;
		logic [31:0] unit_offset;
		logic [31:0] abbrev_code;
		logic [15:0] tag_in;
		logic        children_in;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_CLEAR,
		BK_DONE
	} bk_state_t;

endpackage

/* src/abbrev_hash_table_unit.sv */
// top level of the abbreviation hash table: front classifier, job queue, probe engine
// depends on aht_pkg, aht_front, aht_back
//
//  channel  | handshake          | payload
//  command  | start / busy       | cmd_word (in_word_t)
//  result   | done, one cycle    | result (out_word_t)
//
// a command with zero code, a full insert, a clear or an unused code goes straight from
// idle to done; a probe reads the slot memory and then checks the slot it read, once for
// each slot it visits. busy stays high through the done cycle, so a new word is taken only
// after the result is out; results cannot be held off.
// reset empties the table at once through per-slot valid flops.
module abbrev_hash_table_unit import aht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_word_t  cmd_word,
	output logic      busy,
	output logic      done,
	output out_word_t result
);

	logic job_valid, job_pop, fbusy, pend_q;
	job_t job;

	// hold off new words until the result is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 1'b0;
		else if (start && !busy) pend_q <= 1'b1;
		else if (done) pend_q <= 1'b0;
	end
	assign busy = fbusy || pend_q;

	aht_front u_front (
		.clk, .arst_n, .start(start && !pend_q), .cmd_word, .busy(fbusy),
		.job_valid, .job, .job_pop
	);

	aht_back #(.SLOTS(SLOTS)) u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop, .done, .result
	);

endmodule

/* src/aht_front.sv */
// front end: takes command words, classifies them and queues jobs
// depends on aht_pkg
module aht_front import aht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_word_t cmd_word,
	output logic     busy,
	output logic     job_valid,
	output job_t     job,
	input  logic     job_pop
);

	localparam int PW = $clog2(QDEPTH);

	job_t           q_mem_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PW:0]    fill_q;
	logic           push;
	job_t           new_job;

	// one command in flight at a time: full check needs the count it leaves
	assign busy = (fill_q != '0);
	assign push = start && !busy;

	always_comb begin
		new_job.is_insert    = (cmd_word.command == CMD_INSERT);
		new_job.unit_offset  = cmd_word.unit_offset;
		new_job.abbrev_code  = cmd_word.abbrev_code;
		new_job.tag_in       = cmd_word.tag_in;
		new_job.children_in  = cmd_word.children_in;
		new_job.fixed_status = ST_OK;
		new_job.kind         = JOB_FIXED;
		unique case (cmd_word.command)
			CMD_INSERT, CMD_LOOKUP: begin
				if (cmd_word.abbrev_code == '0) begin
					new_job.fixed_status = ST_ZERO_CODE;
				end else begin
					new_job.kind = JOB_PROBE;
				end
			end
			CMD_CLEAR: new_job.kind = JOB_CLEAR;
			default:   new_job.kind = JOB_FIXED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (job_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			fill_q <= fill_q + (PW+1)'(push) - (PW+1)'(job_pop);
		end
	end

	assign job_valid = (fill_q != '0);
	assign job = q_mem_q[rd_ptr_q];

endmodule

/* src/aht_back.sv */
// back end: probes the slot memory, inserts, clears, forms the result word
// depends on aht_pkg
module aht_back import aht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_pop,
	output logic      done,
	output out_word_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS / 2 + 1);

	typedef struct packed {
		logic [31:0] off;
		logic [31:0] code;
		logic [15:0] tag;
		logic        kids;
	} entry_t;

	entry_t      mem_q [SLOTS];
	entry_t      rd_q;
	logic [SLOTS-1:0] used_q;
	logic        used_rd_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] addr_q;
	logic [SW:0]   probes_q;
	bk_state_t   state_q, state_d;
	out_word_t   res_q;
	logic        done_q;
	logic        hit, full;
	logic        do_write, do_clear, fin;
	out_word_t   res_d;

	assign hit  = rd_q.off == job.unit_offset && rd_q.code == job.abbrev_code;
	assign full = ({1'b0, count_q} << 1) >= (CW+1)'(SLOTS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					unique case (job.kind)
						JOB_PROBE: state_d = (job.is_insert && full) ? BK_DONE : BK_READ;
						JOB_CLEAR: state_d = BK_DONE;
						default:   state_d = BK_DONE;
					endcase
				end
			end
			BK_READ:  state_d = BK_CHECK;
			BK_CHECK: begin
				if (!used_rd_q || hit || probes_q == (SW+1)'(SLOTS - 1)) state_d = BK_DONE;
				else state_d = BK_READ;
			end
			BK_CLEAR: state_d = BK_DONE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		do_write = 1'b0;
		do_clear = 1'b0;
		fin      = 1'b0;
		res_d    = res_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					res_d = '0;
					res_d.entry_count = 7'(count_q);
					if (job.kind == JOB_FIXED) begin
						res_d.status = job.fixed_status;
					end else if (job.kind == JOB_CLEAR) begin
						do_clear = 1'b1;
						res_d.entry_count = '0;
					end else if (job.is_insert && full) begin
						res_d.status = ST_FULL;
					end
				end
			end
			BK_CHECK: begin
				if (!used_rd_q) begin
					if (job.is_insert) begin
						do_write = 1'b1;
						res_d.status = ST_OK;
						res_d.slot = 7'(addr_q);
						res_d.entry_count = 7'(count_q + CW'(1));
					end else begin
						res_d.status = ST_NOT_FOUND;
					end
				end else if (hit) begin
					res_d.status = job.is_insert ? ST_DUPLICATE : ST_OK;
					res_d.slot = 7'(addr_q);
					res_d.tag_out = rd_q.tag;
					res_d.children_out = rd_q.kids;
				end else if (probes_q == (SW+1)'(SLOTS - 1)) begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			BK_DONE: fin = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_write)
			mem_q[addr_q] <= '{job.unit_offset, job.abbrev_code, job.tag_in, job.children_in};
		rd_q <= mem_q[addr_q];
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			used_q    <= '0;
			used_rd_q <= 1'b0;
			count_q   <= '0;
			addr_q    <= '0;
			probes_q  <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			used_rd_q <= used_q[addr_q];
			done_q    <= fin;
			if (do_clear) begin
				used_q  <= '0;
				count_q <= '0;
			end
			if (do_write) begin
				used_q[addr_q] <= 1'b1;
				count_q <= count_q + CW'(1);
			end
			if (state_q == BK_IDLE) begin
				addr_q   <= SW'(job.unit_offset ^ job.abbrev_code);
				probes_q <= '0;
			end else if (state_q == BK_CHECK && state_d == BK_READ) begin
				addr_q   <= addr_q + SW'(1);
				probes_q <= probes_q + (SW+1)'(1);
			end
		end
	end

	assign job_pop = fin;
	assign done    = done_q;
	assign result  = res_q;

endmodule
